@@ rtl/ptc_pkg.sv @@
package ptc_pkg;

	localparam int unsigned RAW_W     = 20;
	localparam int unsigned TEMP_W    = 16;
	localparam int unsigned PRESS_W   = 32;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned SH_P4     = 35;
	localparam int unsigned BIAS_BIT  = 47;

	localparam logic signed [26:0] FINE_OFFSET = 27'sd128000;
	localparam logic [20:0]        P_BASE      = 21'd1048576;
	localparam logic [11:0]        NUM_SCALE   = 12'd3125;
	localparam logic [63:0]        VAR1_BIAS   = 64'd1 << BIAS_BIT;
	localparam logic signed [20:0] TEMP_HI     = 21'sd32767;
	localparam logic signed [20:0] TEMP_LO     = -21'sd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP       = 3'd0,
		CFG_PRESS_A    = 3'd1,
		CFG_PRESS_B    = 3'd2,
		CFG_PRESS_NINE = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} calib_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [63:0]       num;
		logic [30:0]       den;
	} qent_t;

endpackage

@@ rtl/pressure_temperature_compensation.sv @@
// channel | direction | payload
// s_*     | in        | tdata: raw_temperature [19:0], raw_pressure [39:20]
// m_*     | out       | tdata: temperature_centi_c [15:0], pressure_q24_8 [47:16]
//         |           | tuser: divide_guard
// cfg_*   | in        | write of register cfg_index, no read-back
//
// one beat per clock sustained while the output does not stall; a beat passes through
// the front pipeline, then the queue, then the back pipeline
// the back pipeline holds the 64-stage one-bit-per-stage restoring divider
// reset clears the calibration registers, queue pointers and valid bits
// an output stall freezes the back pipeline; the queue absorbs the front until
// it fills, then s_tready drops
module pressure_temperature_compensation #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temperature, raw_pressure
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // temperature_centi_c, pressure_q24_8
	output logic        m_tuser,   // divide_guard
	input  logic        cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptc_pkg::CFG_W-1:0]     cfg_data
);

	logic [47:0]     cal_temp_q;
	logic [63:0]     cal_pa_q;
	logic [63:0]     cal_pb_q;
	logic [15:0]     cal_p9_q;
	ptc_pkg::calib_t cal;

	logic           fq_valid, fq_ready;
	ptc_pkg::qent_t fq_data;
	logic           qb_valid, qb_ready;
	ptc_pkg::qent_t qb_data;

	logic [15:0] temp_out;
	logic [31:0] press_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q <= '0;
			cal_pa_q   <= '0;
			cal_pb_q   <= '0;
			cal_p9_q   <= '0;
		end else if (cfg_we) begin
			case (ptc_pkg::cfg_idx_t'(cfg_index))
				ptc_pkg::CFG_TEMP:       cal_temp_q <= cfg_data[47:0];
				ptc_pkg::CFG_PRESS_A:    cal_pa_q   <= cfg_data;
				ptc_pkg::CFG_PRESS_B:    cal_pb_q   <= cfg_data;
				ptc_pkg::CFG_PRESS_NINE: cal_p9_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cal.t1 = cal_temp_q[15:0];
	assign cal.t2 = cal_temp_q[31:16];
	assign cal.t3 = cal_temp_q[47:32];
	assign cal.p1 = cal_pa_q[15:0];
	assign cal.p2 = cal_pa_q[31:16];
	assign cal.p3 = cal_pa_q[47:32];
	assign cal.p4 = cal_pa_q[63:48];
	assign cal.p5 = cal_pb_q[15:0];
	assign cal.p6 = cal_pb_q[31:16];
	assign cal.p7 = cal_pb_q[47:32];
	assign cal.p8 = cal_pb_q[63:48];
	assign cal.p9 = cal_p9_q;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.raw_temperature (s_tdata[19:0]),
		.raw_pressure    (s_tdata[39:20]),
		.out_valid       (fq_valid),
		.out_ready       (fq_ready),
		.out_data        (fq_data)
	);

	ptc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	ptc_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cal                 (cal),
		.in_valid            (qb_valid),
		.in_ready            (qb_ready),
		.in_data             (qb_data),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.temperature_centi_c (temp_out),
		.pressure_q24_8      (press_out),
		.divide_guard        (m_tuser)
	);

	assign m_tdata = {press_out, temp_out};

endmodule

@@ rtl/ptc_front.sv @@
module ptc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ptc_pkg::calib_t             cal,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ptc_pkg::RAW_W-1:0]   raw_temperature,
	input  logic [ptc_pkg::RAW_W-1:0]   raw_pressure,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ptc_pkg::qent_t              out_data
);

	localparam int unsigned STAGES = 11;

	logic [STAGES-1:0] valid_q;
	logic              ce;

	logic signed [18:0] d1_c;
	logic signed [16:0] d2_c;
	logic [20:0]        pr_c;
	logic signed [34:0] m1_c;
	logic signed [33:0] sq_c;
	logic signed [37:0] b_c;
	logic signed [28:0] t5_c;
	logic signed [20:0] tsh_c;
	logic [15:0]        tsat_c;
	logic signed [37:0] m6hi_c;
	logic signed [37:0] m3hi_c;
	logic [47:0]        yh_c;
	logic [43:0]        wh_c;
	logic [63:0]        prod_c;

	logic signed [18:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic [20:0]        pr_s1, pr_s2, pr_s3, pr_s4, pr_s5, pr_s6, pr_s7, pr_s8;
	logic signed [23:0] a_s2;
	logic signed [21:0] q_s2;
	logic signed [25:0] fine_s3;
	logic signed [26:0] v1_s4;
	logic [15:0]        temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic signed [53:0] vv_s5;
	logic signed [42:0] v5_s5;
	logic signed [42:0] v2p_s5, v2p_s6, v2p_s7;
	logic signed [48:0] m6lo_s6, m3lo_s6;
	logic [31:0]        m6hi_s6, m3hi_s6;
	logic [63:0]        k_s6, k_s7;
	logic [63:0]        pr6_s7;
	logic signed [63:0] pr3_s7;
	logic [63:0]        v2_s8, x_s8;
	logic [63:0]        y_s9, w_s9;
	logic [47:0]        yl_s10;
	logic [31:0]        yh_s10;
	logic [43:0]        wl_s10;
	logic [31:0]        wh_s10;
	ptc_pkg::qent_t     out_s11;

	assign ce        = !valid_q[STAGES-1] || out_ready;
	assign in_ready  = ce;
	assign out_valid = valid_q[STAGES-1];
	assign out_data  = out_s11;

	always_comb begin
		d1_c   = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
		d2_c   = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
		pr_c   = ptc_pkg::P_BASE - {1'b0, raw_pressure};
		m1_c   = d1_s1 * $signed(cal.t2);
		sq_c   = d2_s1 * d2_s1;
		b_c    = q_s2 * $signed(cal.t3);
		t5_c   = 29'(fine_s3) * 29'sd5 + 29'sd128;
		tsh_c  = $signed(t5_c[28:8]);
		if (tsh_c > ptc_pkg::TEMP_HI) begin
			tsat_c = 16'h7FFF;
		end else if (tsh_c < ptc_pkg::TEMP_LO) begin
			tsat_c = 16'h8000;
		end else begin
			tsat_c = tsh_c[15:0];
		end
		m6hi_c = $signed(vv_s5[53:32]) * $signed(cal.p6);
		m3hi_c = $signed(vv_s5[53:32]) * $signed(cal.p3);
		yh_c   = y_s9[63:32] * cal.p1;
		wh_c   = w_s9[63:32] * ptc_pkg::NUM_SCALE;
		prod_c = {16'd0, yl_s10} + {yh_s10, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ce) begin
			valid_q <= {valid_q[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// fine temperature
			d1_s1    <= d1_c;
			d2_s1    <= d2_c;
			pr_s1    <= pr_c;
			a_s2     <= $signed(m1_c[34:11]);
			q_s2     <= $signed(sq_c[33:12]);
			pr_s2    <= pr_s1;
			fine_s3  <= 26'(a_s2) + 26'($signed(b_c[37:14]));
			pr_s3    <= pr_s2;
			v1_s4    <= 27'(fine_s3) - ptc_pkg::FINE_OFFSET;
			temp_s4  <= tsat_c;
			pr_s4    <= pr_s3;
			// pressure divisor and numerator terms
			vv_s5    <= v1_s4 * v1_s4;
			v5_s5    <= v1_s4 * $signed(cal.p5);
			v2p_s5   <= v1_s4 * $signed(cal.p2);
			temp_s5  <= temp_s4;
			pr_s5    <= pr_s4;
			m6lo_s6  <= $signed({1'b0, vv_s5[31:0]}) * $signed(cal.p6);
			m3lo_s6  <= $signed({1'b0, vv_s5[31:0]}) * $signed(cal.p3);
			m6hi_s6  <= m6hi_c[31:0];
			m3hi_s6  <= m3hi_c[31:0];
			k_s6     <= (64'(v5_s5) << 17) + (64'($signed(cal.p4)) << ptc_pkg::SH_P4);
			v2p_s6   <= v2p_s5;
			temp_s6  <= temp_s5;
			pr_s6    <= pr_s5;
			pr6_s7   <= 64'(m6lo_s6) + {m6hi_s6, 32'd0};
			pr3_s7   <= 64'(m3lo_s6) + {m3hi_s6, 32'd0};
			k_s7     <= k_s6;
			v2p_s7   <= v2p_s6;
			temp_s7  <= temp_s6;
			pr_s7    <= pr_s6;
			v2_s8    <= pr6_s7 + k_s7;
			x_s8     <= 64'(pr3_s7 >>> 8) + (64'(v2p_s7) << 12);
			temp_s8  <= temp_s7;
			pr_s8    <= pr_s7;
			y_s9     <= ptc_pkg::VAR1_BIAS + x_s8;
			w_s9     <= (64'(pr_s8) << 31) - v2_s8;
			temp_s9  <= temp_s8;
			yl_s10   <= y_s9[31:0] * cal.p1;
			yh_s10   <= yh_c[31:0];
			wl_s10   <= w_s9[31:0] * ptc_pkg::NUM_SCALE;
			wh_s10   <= wh_c[31:0];
			temp_s10 <= temp_s9;
			out_s11.den  <= prod_c[63:33];
			out_s11.num  <= {20'd0, wl_s10} + {wh_s10, 32'd0};
			out_s11.temp <= temp_s10;
		end
	end

endmodule

@@ rtl/ptc_queue.sv @@
module ptc_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ptc_pkg::qent_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ptc_pkg::qent_t pop_data
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ptc_pkg::qent_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ rtl/ptc_back.sv @@
module ptc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ptc_pkg::calib_t             cal,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ptc_pkg::qent_t              in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ptc_pkg::TEMP_W-1:0]  temperature_centi_c,
	output logic [ptc_pkg::PRESS_W-1:0] pressure_q24_8,
	output logic                        divide_guard
);

	localparam int unsigned STEPS = ptc_pkg::DIV_STEPS;
	localparam int unsigned POST  = 7;

	logic ce;

	logic [STEPS:0]    dv_q;
	logic [POST-1:0]   pv_q;
	logic [30:0]       rem_s  [STEPS+1];
	logic [63:0]       dq_s   [STEPS+1];
	logic [30:0]       ad_s   [STEPS+1];
	logic [STEPS:0]    neg_s;
	logic [STEPS:0]    zero_s;
	logic [15:0]       temp_s [STEPS+1];

	logic signed [63:0] quo_s1, quo_s2, quo_s3, quo_s4, quo_s5;
	logic [15:0]        temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6, temp_s7;
	logic               zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
	logic [63:0]        sq_s2;
	logic [31:0]        cr_s2;
	logic signed [48:0] pl8_s2;
	logic [31:0]        ph8_s2;
	logic [63:0]        aa_s3;
	logic signed [63:0] p8p_s3, p8p_s4, p8p_s5;
	logic signed [48:0] pl9_s4;
	logic [31:0]        ph9_s4;
	logic signed [63:0] v1_s5;
	logic [39:0]        x_s6;
	logic [31:0]        press_s7;
	logic               guard_s7;

	logic signed [63:0] a_c;
	logic [63:0]        cr_c;
	logic [63:0]        ph8_c;
	logic [63:0]        ph9_c;
	logic signed [63:0] pp_c;

	assign ce        = !pv_q[POST-1] || out_ready;
	assign in_ready  = ce;
	assign out_valid = pv_q[POST-1];

	assign temperature_centi_c = temp_s7;
	assign pressure_q24_8      = press_s7;
	assign divide_guard        = guard_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
			pv_q <= '0;
		end else if (ce) begin
			dv_q <= {dv_q[STEPS-1:0], in_valid};
			pv_q <= {pv_q[POST-2:0], dv_q[STEPS]};
		end
	end

	// operand magnitudes
	always_ff @(posedge clk) begin
		if (ce) begin
			dq_s[0]   <= in_data.num[63] ? 64'd0 - in_data.num : in_data.num;
			ad_s[0]   <= in_data.den[30] ? 31'd0 - in_data.den : in_data.den;
			rem_s[0]  <= '0;
			neg_s[0]  <= in_data.num[63] ^ in_data.den[30];
			zero_s[0] <= in_data.den == '0;
			temp_s[0] <= in_data.temp;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic [31:0] trial;
		logic [31:0] diff;
		logic        ge;

		assign trial = {rem_s[k], dq_s[k][63]};
		assign diff  = trial - {1'b0, ad_s[k]};
		assign ge    = trial >= {1'b0, ad_s[k]};

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1]  <= ge ? diff[30:0] : trial[30:0];
				dq_s[k+1]   <= {dq_s[k][62:0], ge};
				ad_s[k+1]   <= ad_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				temp_s[k+1] <= temp_s[k];
			end
		end
	end

	always_comb begin
		a_c   = quo_s1 >>> 13;
		cr_c  = a_c[31:0] * a_c[63:32];
		ph8_c = quo_s1[63:32] * {{16{cal.p8[15]}}, cal.p8};
		ph9_c = aa_s3[63:32] * {{16{cal.p9[15]}}, cal.p9};
		pp_c  = 64'(pl9_s4) + {ph9_s4, 32'd0};
	end

	// quotient correction terms
	always_ff @(posedge clk) begin
		if (ce) begin
			quo_s1   <= neg_s[STEPS] ? 64'd0 - dq_s[STEPS] : dq_s[STEPS];
			zero_s1  <= zero_s[STEPS];
			temp_s1  <= temp_s[STEPS];
			sq_s2    <= a_c[31:0] * a_c[31:0];
			cr_s2    <= cr_c[31:0];
			pl8_s2   <= $signed({1'b0, quo_s1[31:0]}) * $signed(cal.p8);
			ph8_s2   <= ph8_c[31:0];
			quo_s2   <= quo_s1;
			zero_s2  <= zero_s1;
			temp_s2  <= temp_s1;
			aa_s3    <= sq_s2 + {cr_s2[30:0], 33'd0};
			p8p_s3   <= 64'(pl8_s2) + {ph8_s2, 32'd0};
			quo_s3   <= quo_s2;
			zero_s3  <= zero_s2;
			temp_s3  <= temp_s2;
			pl9_s4   <= $signed({1'b0, aa_s3[31:0]}) * $signed(cal.p9);
			ph9_s4   <= ph9_c[31:0];
			p8p_s4   <= p8p_s3;
			quo_s4   <= quo_s3;
			zero_s4  <= zero_s3;
			temp_s4  <= temp_s3;
			v1_s5    <= pp_c >>> 25;
			p8p_s5   <= p8p_s4;
			quo_s5   <= quo_s4;
			zero_s5  <= zero_s4;
			temp_s5  <= temp_s4;
			x_s6     <= 40'(quo_s5 + v1_s5 + (p8p_s5 >>> 19));
			zero_s6  <= zero_s5;
			temp_s6  <= temp_s5;
			press_s7 <= zero_s6 ? '0 : x_s6[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'd0};
			guard_s7 <= zero_s6;
			temp_s7  <= temp_s6;
		end
	end

endmodule

@@ rtl/ptc_checker.sv @@
module ptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input beat changed while stalled");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_guard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:16] == 32'd0)
		else $error("guarded beat with nonzero pressure");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [15:0] temp;
		logic [31:0] press;
		logic        guard;
	} comp_t;

	typedef struct {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		logic        typed;
		comp_t       want;
	} vector_t;

	localparam int LIMIT = 2000000;
	localparam int N_RAND = 1450;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ptc_pkg::CFG_W-1:0]     cfg_data;

	logic [63:0] cal_temp, cal_pa, cal_pb, cal_p9;
	comp_t       expected_q[$];
	int          errors = 0;
	int          beats_out = 0;
	int          guards_seen = 0;
	int          cycles = 0;
	bit          hold_long = 0;

	pressure_temperature_compensation dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [63:0] sx(logic [63:0] v, int pos);
		return {{48{v[pos+15]}}, v[pos +: 16]};
	endfunction

	function automatic logic [63:0] asr(logic [63:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic comp_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
		logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] a, b, d, fine, t, p, v1, v2, an, ad, q, num;
		comp_t r;
		t1 = {48'd0, cal_temp[15:0]};
		t2 = sx(cal_temp, 16);
		t3 = sx(cal_temp, 32);
		p1 = {48'd0, cal_pa[15:0]};
		p2 = sx(cal_pa, 16);
		p3 = sx(cal_pa, 32);
		p4 = sx(cal_pa, 48);
		p5 = sx(cal_pb, 0);
		p6 = sx(cal_pb, 16);
		p7 = sx(cal_pb, 32);
		p8 = sx(cal_pb, 48);
		p9 = sx(cal_p9, 0);
		d = (64'(raw_t) >> 3) - (t1 << 1);
		a = asr(d * t2, 11);
		d = (64'(raw_t) >> 4) - t1;
		b = asr(asr(d * d, 12) * t3, 14);
		fine = a + b;
		t = asr(fine * 5 + 128, 8);
		if ($signed(t) > 32767) t = 32767;
		else if ($signed(t) < -32768) t = -64'sd32768;
		r.temp = t[15:0];
		v1 = fine - 128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = asr(((64'd1 << 47) + v1) * p1, 33);
		if (v1 == 0) begin
			r.press = 0;
			r.guard = 1;
		end else begin
			p = 64'd1048576 - 64'(raw_p);
			num = ((p << 31) - v2) * 3125;
			an = num[63] ? -num : num;
			ad = v1[63] ? -v1 : v1;
			q = an / ad;
			p = (num[63] != v1[63]) ? -q : q;
			a = asr(p, 13);
			v1 = asr(p9 * a * a, 25);
			v2 = asr(p8 * p, 19);
			p = asr(p + v1 + v2, 8) + (p7 << 4);
			r.press = p[31:0];
			r.guard = 0;
		end
		return r;
	endfunction

	task automatic write_reg(ptc_pkg::cfg_idx_t idx, logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			ptc_pkg::CFG_TEMP:       cal_temp = val & 64'hFFFF_FFFF_FFFF;
			ptc_pkg::CFG_PRESS_A:    cal_pa = val;
			ptc_pkg::CFG_PRESS_B:    cal_pb = val;
			ptc_pkg::CFG_PRESS_NINE: cal_p9 = val & 64'hFFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		int n;
		n = 0;
		s_tvalid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		while (n < 100) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic send(logic [19:0] raw_t, logic [19:0] raw_p, bit typed, comp_t want);
		int gap;
		comp_t e;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		e = compensate(raw_t, raw_p);
		if (typed && e != want)
			$display("%0t table row disagrees with predictor: exp %h got %h", $time, want, e);
		expected_q.push_back(typed ? want : e);
		s_tvalid <= 1;
		s_tdata <= {raw_p, raw_t};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_cal;
		write_reg(ptc_pkg::CFG_TEMP, {$urandom, $urandom});
		write_reg(ptc_pkg::CFG_PRESS_A, {$urandom, $urandom});
		write_reg(ptc_pkg::CFG_PRESS_B, {$urandom, $urandom});
		write_reg(ptc_pkg::CFG_PRESS_NINE, 64'($urandom));
	endtask

	task automatic typical_cal;
		write_reg(ptc_pkg::CFG_TEMP, 64'({16'(-16'sd1000 + $urandom_range(0, 2000)),
			16'(26000 + $urandom_range(0, 2000)), 16'(27000 + $urandom_range(0, 2000))}));
		write_reg(ptc_pkg::CFG_PRESS_A, {16'(2855 + $urandom_range(0, 100)),
			16'(-16'sd12 + $urandom_range(0, 24)), -16'sd10000 + 16'($urandom_range(0, 1000)),
			16'(36000 + $urandom_range(0, 2000))});
		write_reg(ptc_pkg::CFG_PRESS_B, {16'(15500), 16'(-16'sd14600), 16'(140), 16'(-16'sd7)});
		write_reg(ptc_pkg::CFG_PRESS_NINE, 64'd6000);
	endtask

	// receiver: random stalls and one long hold-off
	always @(posedge clk) begin
		comp_t got, e;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[47:16], m_tuser};
			beats_out++;
			if (m_tuser) guards_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: exp none got %h", $time, got);
			end else begin
				e = expected_q.pop_front();
				if (got.temp !== e.temp) begin
					errors++;
					$display("%0t temp: exp %h got %h", $time, e.temp, got.temp);
				end
				if (got.press !== e.press) begin
					errors++;
					$display("%0t press: exp %h got %h", $time, e.press, got.press);
				end
				if (got.guard !== e.guard) begin
					errors++;
					$display("%0t guard: exp %b got %b", $time, e.guard, got.guard);
				end
			end
		end
	end

	initial begin
		int w;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (w > 0) begin
				m_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		vector_t rows[$];
		vector_t r;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_index = ptc_pkg::CFG_TEMP;
		cfg_data = 0;
		cal_temp = 0;
		cal_pa = 0;
		cal_pb = 0;
		cal_p9 = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset all coefficients are zero: temp 0, divisor zero
		r.typed = 1;
		r.want = '{temp: 16'd0, press: 32'd0, guard: 1'b1};
		r.raw_t = 0;       r.raw_p = 0;       rows.push_back(r);
		r.raw_t = 20'hFFFFF; r.raw_p = 20'hFFFFF; rows.push_back(r);
		r.raw_t = 20'h55555; r.raw_p = 20'hAAAAA; rows.push_back(r);
		foreach (rows[i]) send(rows[i].raw_t, rows[i].raw_p, rows[i].typed, rows[i].want);
		drain();

		// typical calibration, then extremes of the coefficient space, predictor checked
		typical_cal();
		rows.delete();
		r.typed = 0;
		r.raw_t = 0;         r.raw_p = 0;         rows.push_back(r);
		r.raw_t = 20'hFFFFF; r.raw_p = 20'hFFFFF; rows.push_back(r);
		r.raw_t = 20'h80000; r.raw_p = 20'h52000; rows.push_back(r);
		r.raw_t = 20'h7FFFF; r.raw_p = 20'h00001; rows.push_back(r);
		foreach (rows[i]) send(rows[i].raw_t, rows[i].raw_p, 1'b0, r.want);
		drain();
		write_reg(ptc_pkg::CFG_TEMP, 64'({16'h7FFF, 16'h7FFF, 16'hFFFF}));
		write_reg(ptc_pkg::CFG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(ptc_pkg::CFG_PRESS_B, 64'h8000_8000_8000_8000);
		write_reg(ptc_pkg::CFG_PRESS_NINE, 64'h8000);
		foreach (rows[i]) send(rows[i].raw_t, rows[i].raw_p, 1'b0, r.want);
		drain();
		write_reg(ptc_pkg::CFG_TEMP, 64'({16'h8000, 16'h8000, 16'h0000}));
		write_reg(ptc_pkg::CFG_PRESS_A, 64'h7FFF_7FFF_7FFF_0001);
		write_reg(ptc_pkg::CFG_PRESS_B, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(ptc_pkg::CFG_PRESS_NINE, 64'h7FFF);
		foreach (rows[i]) send(rows[i].raw_t, rows[i].raw_p, 1'b0, r.want);
		drain();

		// random phases: mostly realistic calibration, some fully random
		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 3 == 2) random_cal(); else typical_cal();
			if (ph == 4) write_reg(ptc_pkg::CFG_PRESS_A, cal_pa & ~64'hFFFF);
			for (int k = 0; k < N_RAND / 10; k++) begin
				if (ph == 1 && k == 20) hold_long = 1;
				if ($urandom_range(0, 3) == 0)
					send(20'($urandom), 20'($urandom), 1'b0, r.want);
				else
					send(20'(20'h70000 + $urandom_range(0, 20'h18000)),
						20'(20'h40000 + $urandom_range(0, 20'h30000)), 1'b0, r.want);
			end
			drain();
		end

		$display("%0d result beats checked over several calibrations, %0d with divide guard",
			beats_out, guards_seen);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

@@ pressure_temperature_compensation.f @@
rtl/ptc_pkg.sv
rtl/ptc_front.sv
rtl/ptc_queue.sv
rtl/ptc_back.sv
rtl/pressure_temperature_compensation.sv
rtl/ptc_checker.sv
sim/testbench.sv
